// File: sv/touch_report_compiler_unit_assert.svh
// Assertion macros for the touch report compiler.
// Used by touch_report_compiler_unit; expects i_clk and i_rst_n in scope.
`ifndef TOUCH_REPORT_COMPILER_UNIT_ASSERT_SVH
`define TOUCH_REPORT_COMPILER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define TRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRC_ASSERT_SAME(lbl, ante, cons, msg)
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/trc_pkg.sv
// Shared types and constants for the touch report compiler.
// No dependencies; used by touch_report_compiler_unit.
`default_nettype none

package trc_pkg;

    // Default slot count and register reset values
    localparam int FINGERS_DEF = 5;
    localparam logic [15:0] HOVER_X_RST = 16'd6592;
    localparam logic [15:0] HOVER_Y_RST = 16'd4352;
    localparam logic [7:0]  PRESSURE_MAX = 8'hFF;

    // Reciprocals for divide by 10 (16-bit magnitudes) and by 100 (32-bit)
    localparam logic [15:0] RECIP_10     = 16'd52429;
    localparam int          RECIP_10_SH  = 19;
    localparam logic [31:0] RECIP_100    = 32'h51EB851F;
    localparam int          RECIP_100_SH = 37;

    // Finger flag bit positions
    localparam int FLAG_CONF    = 0;
    localparam int FLAG_TIP     = 1;
    localparam int FLAG_INRANGE = 2;

    // Record kinds
    localparam logic REC_FINGER  = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    // Register indexes (byte address bit 2)
    localparam logic REG_HOVER_X = 1'b0;
    localparam logic REG_HOVER_Y = 1'b1;

    // One input request
    typedef struct packed {
        logic        finger_valid;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] contact_width;
        logic [15:0] contact_height;
        logic [7:0]  pressure_in;
        logic        is_palm;
        logic [15:0] angle;
        logic        hover_seen;
        logic        click;
        logic [31:0] time_us;
        logic        last_slot;
    } t_in_item;

    // One result record
    typedef struct packed {
        logic              record_kind;
        logic [2:0]        slot_or_count;
        logic [2:0]        flags;
        logic [15:0]       out_x;
        logic [15:0]       out_y;
        logic [15:0]       out_width;
        logic [15:0]       out_height;
        logic [7:0]        out_pressure;
        logic [15:0]       out_angle;
        logic signed [7:0] mouse_dx;
        logic signed [7:0] mouse_dy;
        logic [15:0]       scan_time;
    } t_out_item;

    // Stored report of one slot
    typedef struct packed {
        logic [2:0]  flags;
        logic [15:0] angle;
        logic [7:0]  pressure;
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] y;
        logic [15:0] x;
    } t_entry;

    // Slot 0 of the previous frame
    typedef struct packed {
        logic        inrange;
        logic        tip;
        logic [15:0] y;
        logic [15:0] x;
    } t_prior;

endpackage

`default_nettype wire

// File: sv/touch_report_compiler_unit.sv
// Touch report compiler: per-slot finger requests in, frame report records out.
// Depends on trc_pkg and touch_report_compiler_unit_assert.svh.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+----------------------
//   in       | input     | i_in_valid / o_in_ready      | i_in_data  (t_in_item)
//   out      | output    | o_out_valid / i_out_ready    | o_out_data (t_out_item)
//   config   | input     | psel penable pwrite / pready | paddr pwdata / prdata
//
// A slot request is accepted, then a read-modify-write of the slot memory
// follows (one port each way, registered read). A last-slot request adds
// a slot step per missing slot, a hover step, a memory read and an output step
// per finger record, a delta-scaling step and a summary step; the output steps
// hold while the output stalls.
// Reset is synchronous and clears control, slot valid bits and registers.
`default_nettype none

module touch_report_compiler_unit #(
    parameter int FINGERS = trc_pkg::FINGERS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input request channel
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  trc_pkg::t_in_item   i_in_data,
    // output record channel
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output trc_pkg::t_out_item  o_out_data,
    // configuration port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

`include "touch_report_compiler_unit_assert.svh"

    localparam int AW = (FINGERS > 1) ? $clog2(FINGERS) : 1;
    localparam int CW = $clog2(FINGERS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROC  = 7'b0000010,
        S_HOVER = 7'b0000100,
        S_ERD   = 7'b0001000,
        S_EOUT  = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_SUM   = 7'b1000000
    } t_state;

    // control and datapath registers
    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_total;
    logic [CW-1:0]       r_eidx;
    logic                r_first;
    trc_pkg::t_in_item   r_in;
    trc_pkg::t_prior     r_prior;
    logic [15:0]         r_hover_x, r_hover_y;
    logic                r_ovld;
    trc_pkg::t_out_item  r_odata, n_odata;

    // delta pipeline
    logic                r_dmove;
    logic                r_dneg_x, r_dneg_y;
    logic [15:0]         r_dabs_x, r_dabs_y;
    logic [31:0]         r_px, r_py;
    logic [63:0]         r_tprod;

    // slot memory
    trc_pkg::t_entry     r_mem [FINGERS];
    logic [FINGERS-1:0]  r_vld;
    trc_pkg::t_entry     r_rdata;
    logic                r_rvld;

    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    trc_pkg::t_entry     wr_data;

    logic                in_acc, out_free, cfg_wr, out_load;
    trc_pkg::t_entry     rd_entry, proc_entry;
    logic                proc_inc;
    logic [CW-1:0]       cnt_inc, eidx_inc;
    logic [16:0]         diff_x, diff_y;
    logic [12:0]         qx, qy;
    logic [6:0]          sat_x, sat_y;
    logic signed [7:0]   dx, dy;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovld || i_out_ready;
    assign out_load = ((r_state == S_EOUT) || (r_state == S_SUM)) && out_free;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cnt_inc  = r_cnt + CW'(1);
    assign eidx_inc = r_eidx + CW'(1);
    assign rd_entry = r_rvld ? r_rdata : '0;

    // Slot update: new finger, lifted finger, or cleared slot
    always_comb begin
        proc_entry = '0;
        proc_inc   = 1'b0;
        if (r_first && r_in.finger_valid) begin
            proc_entry.x        = r_in.pos_x;
            proc_entry.y        = r_in.pos_y;
            proc_entry.width    = r_in.contact_width;
            proc_entry.height   = r_in.contact_height;
            proc_entry.pressure = r_in.is_palm ? trc_pkg::PRESSURE_MAX : r_in.pressure_in;
            proc_entry.angle    = r_in.angle;
            proc_entry.flags    = 3'b111;
            proc_inc            = 1'b1;
        end else if (rd_entry.flags[trc_pkg::FLAG_TIP]) begin
            proc_entry       = rd_entry;
            proc_entry.flags = 3'b000;
            proc_entry.flags[trc_pkg::FLAG_CONF] = 1'b1;
            proc_inc         = 1'b1;
        end
    end

    // Sequencer and memory port control
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = r_cnt[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_data = proc_entry;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_cnt < CW'(FINGERS)) begin
                        rd_en   = 1'b1;
                        n_state = S_PROC;
                    end else if (i_in_data.last_slot) begin
                        n_state = S_HOVER;
                    end
                end
            end
            S_PROC: begin
                wr_en = 1'b1;
                if (r_in.last_slot && (cnt_inc < CW'(FINGERS))) begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_inc[AW-1:0];
                end else if (r_in.last_slot) begin
                    n_state = S_HOVER;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HOVER: begin
                wr_addr = '0;
                wr_data = '0;
                wr_data.x = r_hover_x;
                wr_data.y = r_hover_y;
                wr_data.flags[trc_pkg::FLAG_INRANGE] = 1'b1;
                wr_en   = (r_total == '0) && r_in.hover_seen;
                n_state = S_ERD;
            end
            S_ERD: begin
                rd_en   = 1'b1;
                rd_addr = r_eidx[AW-1:0];
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (out_free) begin
                    n_state = (eidx_inc == CW'(FINGERS)) ? S_SCALE : S_ERD;
                end
            end
            S_SCALE: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Per-slot valid bits; an unwritten slot reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rvld <= r_vld[rd_addr];
            end
        end
    end

    // Slot 0 movement against the previous frame
    assign diff_x = {1'b0, rd_entry.x} - {1'b0, r_prior.x};
    assign diff_y = {1'b0, rd_entry.y} - {1'b0, r_prior.y};

    // Quotient by 10, saturated and signed
    assign qx    = r_px[31:trc_pkg::RECIP_10_SH];
    assign qy    = r_py[31:trc_pkg::RECIP_10_SH];
    assign sat_x = (qx > 13'd127) ? 7'd127 : qx[6:0];
    assign sat_y = (qy > 13'd127) ? 7'd127 : qy[6:0];
    assign dx    = !r_dmove ? 8'sd0 :
                   r_dneg_x ? -$signed({1'b0, sat_x}) : $signed({1'b0, sat_x});
    assign dy    = !r_dmove ? 8'sd0 :
                   r_dneg_y ? -$signed({1'b0, sat_y}) : $signed({1'b0, sat_y});

    // Control, frame state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_total   <= '0;
            r_eidx    <= '0;
            r_first   <= 1'b0;
            r_prior   <= '0;
            r_hover_x <= trc_pkg::HOVER_X_RST;
            r_hover_y <= trc_pkg::HOVER_Y_RST;
            r_ovld    <= 1'b0;
            r_dmove   <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (cfg_wr) begin
                if (paddr[2] == trc_pkg::REG_HOVER_Y) begin
                    r_hover_y <= pwdata[15:0];
                end else begin
                    r_hover_x <= pwdata[15:0];
                end
            end

            // output valid: set when a record loads, cleared once taken
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_first <= 1'b1;
                    end
                end
                S_PROC: begin
                    r_first <= 1'b0;
                    r_cnt   <= cnt_inc;
                    if (proc_inc) begin
                        r_total <= r_total + CW'(1);
                    end
                end
                S_HOVER: begin
                    r_cnt  <= '0;
                    r_eidx <= '0;
                    if (r_total == '0) begin
                        if (r_in.hover_seen || (!r_prior.tip && r_prior.inrange)) begin
                            r_total <= CW'(1);
                        end
                    end
                end
                S_EOUT: begin
                    if (out_free) begin
                        r_eidx <= eidx_inc;
                        if (r_eidx == '0) begin
                            r_dmove <= rd_entry.flags[trc_pkg::FLAG_TIP] && r_prior.tip;
                            r_prior <= {rd_entry.flags[trc_pkg::FLAG_INRANGE],
                                        rd_entry.flags[trc_pkg::FLAG_TIP],
                                        rd_entry.y, rd_entry.x};
                        end
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_total <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Next output record: finger record while stepping slots, else summary
    always_comb begin
        n_odata = '0;
        if (r_state == S_EOUT) begin
            n_odata.record_kind   = trc_pkg::REC_FINGER;
            n_odata.slot_or_count = 3'(r_eidx);
            n_odata.flags         = rd_entry.flags;
            n_odata.out_x         = rd_entry.x;
            n_odata.out_y         = rd_entry.y;
            n_odata.out_width     = rd_entry.width;
            n_odata.out_height    = rd_entry.height;
            n_odata.out_pressure  = rd_entry.pressure;
            n_odata.out_angle     = rd_entry.angle;
        end else begin
            n_odata.record_kind   = trc_pkg::REC_SUMMARY;
            n_odata.slot_or_count = 3'(r_total);
            n_odata.flags         = {2'b00, r_in.click};
            n_odata.mouse_dx      = dx;
            n_odata.mouse_dy      = dy;
            n_odata.scan_time     = r_tprod[trc_pkg::RECIP_100_SH +: 16];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (r_state == S_HOVER) begin
            r_tprod <= r_in.time_us * trc_pkg::RECIP_100;
        end
        if ((r_state == S_EOUT) && out_free && (r_eidx == '0)) begin
            r_dneg_x <= diff_x[16];
            r_dneg_y <= diff_y[16];
            r_dabs_x <= diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
            r_dabs_y <= diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
        end
        if (r_state == S_SCALE) begin
            r_px <= r_dabs_x * trc_pkg::RECIP_10;
            r_py <= r_dabs_y * trc_pkg::RECIP_10;
        end
        if (out_load) begin
            r_odata <= n_odata;
        end
    end

    // Ports
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == trc_pkg::REG_HOVER_Y) ? {16'd0, r_hover_y}
                                                           : {16'd0, r_hover_x};

    // Checks
    `TRC_ASSERT_SAME(a_cnt_range, 1'b1, (r_cnt <= CW'(FINGERS)) && (r_total <= CW'(FINGERS)),
        "slot counter or contact count beyond slot depth")
    `TRC_ASSERT_NEXT(a_accept_path, in_acc,
        (r_state == S_PROC) || (r_state == S_HOVER) || (r_state == S_IDLE),
        "accepted request did not start slot processing")
    `TRC_ASSERT_NEXT(a_summary_end, (r_state == S_SUM) && out_free,
        (r_state == S_IDLE) && (r_cnt == '0) && (r_total == '0) && o_out_valid,
        "frame did not close after summary record")
    `TRC_ASSERT_SAME(a_mem_ports, rd_en && wr_en && (r_state == S_PROC),
        rd_addr != wr_addr,
        "slot read and write collide in one cycle")

endmodule

`default_nettype wire
